### rtl/core/iaf_pkg.sv
// Package for the ARMA filter: coefficient format, register indexes, widths
// and the control bundle between sequencer and multiply-accumulate unit.
// Depends on nothing.
`timescale 1ns / 1ps

package iaf_pkg;

	// Coefficient format: signed Q2.14.
	localparam int COEF_BITS    = 16;
	localparam int FRAC_BITS    = 14;

	// Configuration register file.
	localparam int NUM_REGS     = 8;
	localparam int REG_IDX_BITS = 3;
	localparam int CFG_IDX_BITS = 4;

	// Register indexes.
	localparam logic [REG_IDX_BITS-1:0] REG_FF_COEF_0 = 3'd0;
	localparam logic [REG_IDX_BITS-1:0] REG_FF_COEF_1 = 3'd1;
	localparam logic [REG_IDX_BITS-1:0] REG_FF_COEF_2 = 3'd2;
	localparam logic [REG_IDX_BITS-1:0] REG_FF_COEF_3 = 3'd3;
	localparam logic [REG_IDX_BITS-1:0] REG_FB_COEF_1 = 3'd4;
	localparam logic [REG_IDX_BITS-1:0] REG_FB_COEF_2 = 3'd5;
	localparam logic [REG_IDX_BITS-1:0] REG_FB_COEF_3 = 3'd6;
	localparam logic [REG_IDX_BITS-1:0] REG_FB_COEF_4 = 3'd7;

	// Reset value of the current-input coefficient (1.0 in Q2.14).
	localparam logic signed [COEF_BITS-1:0] FF0_RESET = 16'sd16384;

	// Tap structure.
	localparam int MAX_TAPS     = 4;
	localparam int TAP_IDX_BITS = 2;

	// Headroom of the accumulator over one product (eight terms plus rounding).
	localparam int GUARD_BITS   = 4;

	// Defaults of the top-level parameters.
	localparam int DEF_TAP_COUNT   = 4;
	localparam int DEF_SAMPLE_BITS = 16;

	// Control from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic clear;   // zero the accumulator and drop any pending product
		logic mul_en;  // form a product this cycle
		logic fb;      // the product is a feedback term and is subtracted
	} mac_ctl_t;

endpackage

### rtl/core/iaf_if.sv
// Channel interfaces of the ARMA filter: sample input, filtered output and
// configuration write. Depends on iaf_pkg.
`timescale 1ns / 1ps

interface iaf_in_if #(
	parameter int SAMPLE_BITS = iaf_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink   (input valid, input sample_in, output ready);
endinterface

interface iaf_out_if #(
	parameter int SAMPLE_BITS = iaf_pkg::DEF_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, output sample_out, output clipped, input ready);
	modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

interface iaf_cfg_if;
	logic                                    valid;
	logic                                    ready;
	logic [iaf_pkg::CFG_IDX_BITS-1:0]        index;
	logic signed [iaf_pkg::COEF_BITS-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/iaf_mac.sv
// Shared multiply-accumulate unit with rounding and saturation of the sum.
// Depends on iaf_pkg.
`timescale 1ns / 1ps

module iaf_mac #(
	parameter int SAMPLE_BITS = iaf_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  iaf_pkg::mac_ctl_t                    ctl,
	input  logic signed [iaf_pkg::COEF_BITS-1:0] coef,
	input  logic signed [SAMPLE_BITS-1:0]        opnd,
	output logic signed [SAMPLE_BITS-1:0]        y,
	output logic                                 clip
);

	localparam int PW  = iaf_pkg::COEF_BITS + SAMPLE_BITS;
	localparam int AW  = PW + iaf_pkg::GUARD_BITS;
	localparam int YW  = AW - iaf_pkg::FRAC_BITS;

	localparam logic signed [AW-1:0] HALF  = AW'(1 << (iaf_pkg::FRAC_BITS - 1));
	localparam logic signed [YW-1:0] Y_MAX = YW'((1 << (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [YW-1:0] Y_MIN = ~Y_MAX;

	logic signed [PW-1:0] prod_s1;
	logic                 pv_s1;
	logic                 fb_s1;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] rnd_sum;
	logic signed [YW-1:0] y_wide;

	// Product stage: one multiplication per cycle, registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else if (ctl.clear) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_s1 <= coef * opnd;
			fb_s1   <= ctl.fb;
		end
	end

	// Accumulator: feedforward terms add, feedback terms subtract.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clear) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			if (fb_s1) begin
				acc_q <= acc_q - AW'(prod_s1);
			end else begin
				acc_q <= acc_q + AW'(prod_s1);
			end
		end
	end

	// Round half up, drop the fraction bits and saturate to the sample range.
	always_comb begin
		rnd_sum = acc_q + HALF;
		y_wide  = YW'(rnd_sum >>> iaf_pkg::FRAC_BITS);
		if (y_wide > Y_MAX) begin
			y    = Y_MAX[SAMPLE_BITS-1:0];
			clip = 1'b1;
		end else if (y_wide < Y_MIN) begin
			y    = Y_MIN[SAMPLE_BITS-1:0];
			clip = 1'b1;
		end else begin
			y    = y_wide[SAMPLE_BITS-1:0];
			clip = 1'b0;
		end
	end

endmodule

### rtl/core/iir_arma_filter_top.sv
// Top level of the direct-form-1 ARMA filter: coefficient registers, sample
// histories and the sequencer that drives the shared multiply-accumulate unit.
// Depends on iaf_pkg, iaf_if and iaf_mac.
//
//  Channel   Direction  Payload                       Transfer when
//  smp_in    sink       sample_in                     valid && ready
//  smp_out   source     sample_out, clipped           valid && ready
//  cfg       sink       index, data                   valid && ready
//
// A sample is not taken until the previous one is done: after its transfer the
// sequencer forms one product per cycle through the single multiplier, drains the
// product register, rounds, and goes back to idle, where the next transfer lands.
// Reset clears the histories to zero and loads the coefficient reset values.
// The result waits in an output register, so a new sample is taken while it is
// stalled; the rounding step holds only if the previous result is still there.
// Configuration writes are always taken.
`timescale 1ns / 1ps

module iir_arma_filter_top #(
	parameter int TAP_COUNT   = iaf_pkg::DEF_TAP_COUNT,
	parameter int SAMPLE_BITS = iaf_pkg::DEF_SAMPLE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	iaf_in_if.sink    smp_in,
	iaf_out_if.source smp_out,
	iaf_cfg_if.sink   cfg
);

	localparam logic [iaf_pkg::TAP_IDX_BITS-1:0] LAST_TAP =
		iaf_pkg::TAP_IDX_BITS'(TAP_COUNT - 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MAC  = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_RND  = 4'b1000
	} state_t;

	state_t                                state_q;
	logic [iaf_pkg::TAP_IDX_BITS-1:0]      tap_q;
	logic                                  ph_q;
	logic signed [iaf_pkg::COEF_BITS-1:0]  coef_q [iaf_pkg::NUM_REGS];
	logic signed [SAMPLE_BITS-1:0]         xw_q [iaf_pkg::MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0]         yh_q [iaf_pkg::MAX_TAPS];
	logic                                  out_valid_q;
	logic signed [SAMPLE_BITS-1:0]         sample_out_q;
	logic                                  clipped_q;

	iaf_pkg::mac_ctl_t                     ctl;
	logic signed [iaf_pkg::COEF_BITS-1:0]  coef_sel;
	logic signed [SAMPLE_BITS-1:0]         opnd_sel;
	logic signed [SAMPLE_BITS-1:0]         mac_y;
	logic                                  mac_clip;
	logic                                  in_xfer;
	logic                                  out_free;
	logic                                  done;

	assign smp_in.ready = (state_q == ST_IDLE);
	assign in_xfer      = smp_in.valid && smp_in.ready;
	assign out_free     = !out_valid_q || smp_out.ready;
	assign done         = (state_q == ST_RND) && out_free;

	assign cfg.ready    = 1'b1;

	assign smp_out.valid      = out_valid_q;
	assign smp_out.sample_out = sample_out_q;
	assign smp_out.clipped    = clipped_q;

	// Coefficient registers; indexes past the register file are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iaf_pkg::NUM_REGS; i++) begin
				coef_q[i] <= (i == int'(iaf_pkg::REG_FF_COEF_0)) ?
					iaf_pkg::FF0_RESET : '0;
			end
		end else if (cfg.valid && cfg.ready &&
				cfg.index < iaf_pkg::CFG_IDX_BITS'(iaf_pkg::NUM_REGS)) begin
			coef_q[cfg.index[iaf_pkg::REG_IDX_BITS-1:0]] <= cfg.data;
		end
	end

	// Sequencer: one term per cycle, feedforward and feedback interleaved.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
			ph_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= ST_MAC;
						tap_q   <= '0;
						ph_q    <= 1'b0;
					end
				end
				ST_MAC: begin
					ph_q <= !ph_q;
					if (ph_q) begin
						tap_q <= tap_q + 1'b1;
						if (tap_q == LAST_TAP) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Operand selection for the shared unit.
	always_comb begin
		coef_sel   = coef_q[{ph_q, tap_q}];
		opnd_sel   = ph_q ? yh_q[tap_q] : xw_q[tap_q];
		ctl.clear  = in_xfer;
		ctl.mul_en = (state_q == ST_MAC);
		ctl.fb     = ph_q;
	end

	iaf_mac #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.coef   (coef_sel),
		.opnd   (opnd_sel),
		.y      (mac_y),
		.clip   (mac_clip)
	);

	// Sample histories: entry zero of the input line holds the current sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < iaf_pkg::MAX_TAPS; i++) begin
				xw_q[i] <= '0;
				yh_q[i] <= '0;
			end
		end else begin
			if (in_xfer) begin
				xw_q[0] <= smp_in.sample_in;
			end
			if (done) begin
				for (int i = 1; i < iaf_pkg::MAX_TAPS; i++) begin
					xw_q[i] <= xw_q[i-1];
					yh_q[i] <= yh_q[i-1];
				end
				yh_q[0] <= mac_y;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (smp_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			sample_out_q <= mac_y;
			clipped_q    <= mac_clip;
		end
	end

endmodule

### rtl/core/iaf_checker.sv
// Port-level checks of the ARMA filter and their attachment to the top level.
// Depends on the top level iir_arma_filter_top.
`timescale 1ns / 1ps

module iaf_checker #(
	parameter int SAMPLE_BITS = iaf_pkg::DEF_SAMPLE_BITS
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [SAMPLE_BITS-1:0] out_sample,
	input logic                   out_clipped
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample) && $stable(out_clipped))
		else $error("result payload changed while stalled");

	// The filter works on one sample at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second sample taken while the first is in work");

	// A new result never appears on the edge after a sample transfer.
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared too soon after a sample transfer");

endmodule

bind iir_arma_filter_top iaf_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_iaf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (smp_in.valid),
	.in_ready    (smp_in.ready),
	.out_valid   (smp_out.valid),
	.out_ready   (smp_out.ready),
	.out_sample  (smp_out.sample_out),
	.out_clipped (smp_out.clipped)
);

### sim/iir_arma_filter_top_tb.sv
// Self-checking testbench for iir_arma_filter_top: directed samples and writes with
// typed or bit-true predicted results, then random phases against the predictor.
// Depends on iaf_pkg, iaf_if and the filter RTL.
`timescale 1ns / 1ps

module iir_arma_filter_top_tb;

	import iaf_pkg::*;

	localparam int TAPS        = DEF_TAP_COUNT;
	localparam int SAMPLE_W    = DEF_SAMPLE_BITS;
	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 2 * TAPS + 3 + 10;
	localparam int MAX_REPORTS = 40;
	localparam int PHASES      = 14;
	localparam int PHASE_ITEMS = 131;
	localparam int DIR_ROWS    = 27;

	localparam logic signed [SAMPLE_W-1:0]  SMP_MAX  = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0]  SMP_MIN  = 16'sh8000;
	localparam logic signed [COEF_BITS-1:0] COEF_MAX = 16'sh7FFF;
	localparam logic signed [COEF_BITS-1:0] COEF_MIN = 16'sh8000;
	localparam logic [CFG_IDX_BITS-1:0] IDX_UNMAPPED = 4'd9;
	localparam int CFG_IDX_TOP = (1 << CFG_IDX_BITS) - 1;

	// Expectation source of a directed row.
	localparam logic TYPED     = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

	// Coefficient styles for the random phases.
	typedef enum int {CS_FULL, CS_MODERATE, CS_EXTREME, CS_ZERO, CS_SMALL} coef_style_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       clipped;
	} filter_result_t;

	typedef struct packed {
		row_kind_t                  kind;
		logic [CFG_IDX_BITS-1:0]    idx;
		logic signed [15:0]         value;
		logic                       typed;
		logic signed [SAMPLE_W-1:0] exp_sample;
		logic                       exp_clip;
	} dir_row_t;

	logic clk;
	logic arst_n;

	iaf_in_if  #(.SAMPLE_BITS(SAMPLE_W)) smp_in_if ();
	iaf_out_if #(.SAMPLE_BITS(SAMPLE_W)) smp_out_if ();
	iaf_cfg_if                           cfg_if ();

	iir_arma_filter_top #(
		.TAP_COUNT   (TAPS),
		.SAMPLE_BITS (SAMPLE_W)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.smp_in  (smp_in_if),
		.smp_out (smp_out_if),
		.cfg     (cfg_if)
	);

	// Predictor state: coefficient bank and the two sample histories.
	logic signed [COEF_BITS-1:0] coef_bank [NUM_REGS];
	logic signed [SAMPLE_W-1:0]  x_hist [MAX_TAPS-1];
	logic signed [SAMPLE_W-1:0]  y_hist [MAX_TAPS];

	filter_result_t expected_results [$];
	filter_result_t typed_result;
	logic           typed_pending;
	int             sent_count;
	int             recv_count;
	int             errors;
	int             cycles;
	int             burst_left;
	bit             no_idle;

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Computes the filtered sample for x and advances the histories.
	function automatic filter_result_t filter_predict(input logic signed [SAMPLE_W-1:0] x);
		longint         acc;
		longint         y;
		longint         xk;
		filter_result_t r;
		acc = 0;
		for (int k = 0; k < TAPS && k < MAX_TAPS; k++) begin
			xk  = (k == 0) ? longint'(x) : longint'(x_hist[k-1]);
			acc += longint'(coef_bank[k]) * xk;
			acc -= longint'(coef_bank[MAX_TAPS + k]) * longint'(y_hist[k]);
		end
		// Round half up, then floor through the arithmetic shift.
		y = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
		r.clipped = 1'b0;
		if (y > longint'(SMP_MAX)) begin
			y = longint'(SMP_MAX);
			r.clipped = 1'b1;
		end else if (y < longint'(SMP_MIN)) begin
			y = longint'(SMP_MIN);
			r.clipped = 1'b1;
		end
		r.sample = y[SAMPLE_W-1:0];
		for (int k = MAX_TAPS - 2; k > 0; k--)
			x_hist[k] = x_hist[k-1];
		x_hist[0] = x;
		for (int k = MAX_TAPS - 1; k > 0; k--)
			y_hist[k] = y_hist[k-1];
		y_hist[0] = r.sample;
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return SMP_MAX;
			1:       return SMP_MIN;
			2:       return $urandom_range(0, 1) ? 16'sd0 : -16'sd1;
			3, 4, 5: return 16'(int'($urandom_range(0, 4000)) - 2000);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [COEF_BITS-1:0] pick_coef(input coef_style_t style);
		case (style)
			CS_MODERATE: return 16'(int'($urandom_range(0, 16384)) - 8192);
			CS_EXTREME:  return $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;
			CS_ZERO:     return '0;
			CS_SMALL:    return 16'(int'($urandom_range(0, 4096)) - 2048);
			default:     return 16'($urandom);
		endcase
	endfunction

	// Offers one sample, pacing the sender in bursts with random gaps.
	task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic typed,
				   input filter_result_t typed_res);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
			if (gap != 0) begin
				smp_in_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		smp_in_if.valid     <= 1'b1;
		smp_in_if.sample_in <= s;
		typed_pending       <= typed;
		typed_result        <= typed_res;
		@(posedge clk);
		while (!smp_in_if.ready) @(posedge clk);
		sent_count++;
	endtask

	// Leaves valid high; the caller lowers it after the last write of a sequence.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
				 input logic signed [COEF_BITS-1:0] value);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= value;
		@(posedge clk);
		while (!cfg_if.ready) @(posedge clk);
	endtask

	// Stops offering samples and waits until every result has come back.
	task automatic wait_idle();
		smp_in_if.valid <= 1'b0;
		while (recv_count != sent_count) @(posedge clk);
	endtask

	// Receiver: free-flowing, randomly stalling or long-stalling stretches.
	initial begin
		smp_out_if.ready = 1'b0;
		forever begin
			case ($urandom_range(0, 2))
				0: begin
					smp_out_if.ready <= 1'b1;
					repeat ($urandom_range(10, 60)) @(posedge clk);
				end
				1: begin
					repeat ($urandom_range(10, 60)) begin
						smp_out_if.ready <= 1'($urandom_range(0, 1));
						@(posedge clk);
					end
				end
				default: begin
					smp_out_if.ready <= 1'b0;
					repeat ($urandom_range(1, 32)) @(posedge clk);
					smp_out_if.ready <= 1'b1;
					repeat ($urandom_range(1, 4)) @(posedge clk);
				end
			endcase
		end
	end

	// Watchdog on the total run length.
	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles", $time, cycles);
			$display("iir_arma_filter_top verification failed");
			$finish;
		end
	end

	// Observes every transfer: register writes, accepted samples and results.
	always @(posedge clk) begin
		filter_result_t want;
		if (arst_n) begin
			if (cfg_if.valid && cfg_if.ready && cfg_if.index < NUM_REGS)
				coef_bank[cfg_if.index[REG_IDX_BITS-1:0]] = cfg_if.data;
			if (smp_in_if.valid && smp_in_if.ready) begin
				want = filter_predict(smp_in_if.sample_in);
				expected_results.push_back(typed_pending ? typed_result : want);
			end
			if (smp_out_if.valid && smp_out_if.ready) begin
				recv_count++;
				if (expected_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t unexpected result: sample_out %0d clipped %0b",
							 $time, smp_out_if.sample_out, smp_out_if.clipped);
				end else begin
					want = expected_results.pop_front();
					if (smp_out_if.sample_out !== want.sample) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t sample_out mismatch: expected %0d actual %0d",
								 $time, want.sample, smp_out_if.sample_out);
					end
					if (smp_out_if.clipped !== want.clipped) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t clipped mismatch: expected %0b actual %0b",
								 $time, want.clipped, smp_out_if.clipped);
					end
				end
			end
		end
	end

	// Reset, directed table, random phases and the final verdict.
	initial begin
		dir_row_t       dir_table [DIR_ROWS];
		filter_result_t no_result;
		coef_style_t    ff_style;
		coef_style_t    fb_style;
		logic signed [COEF_BITS-1:0] value;

		// Directed table: reset response, saturation at both ends, an ignored
		// write to an unmapped index, then a full set of mixed and extreme coefficients.
		dir_table = '{
			'{ROW_SAMPLE, '0,            16'sd0,      TYPED,     16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            SMP_MAX,     TYPED,     SMP_MAX,    1'b0},
			'{ROW_SAMPLE, '0,            SMP_MIN,     TYPED,     SMP_MIN,    1'b0},
			'{ROW_SAMPLE, '0,            -16'sd1,     TYPED,     -16'sd1,    1'b0},
			'{ROW_SAMPLE, '0,            16'sd1,      TYPED,     16'sd1,     1'b0},
			'{ROW_CFG,    REG_FF_COEF_0, COEF_MAX,    PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            SMP_MAX,     TYPED,     SMP_MAX,    1'b1},
			'{ROW_SAMPLE, '0,            SMP_MIN,     TYPED,     SMP_MIN,    1'b1},
			'{ROW_CFG,    REG_FF_COEF_0, COEF_MIN,    PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            SMP_MIN,     TYPED,     SMP_MAX,    1'b1},
			'{ROW_SAMPLE, '0,            SMP_MAX,     TYPED,     SMP_MIN,    1'b1},
			'{ROW_CFG,    IDX_UNMAPPED,  16'sd0,      PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            16'sd5,      TYPED,     -16'sd10,   1'b0},
			'{ROW_CFG,    REG_FF_COEF_0, FF0_RESET,   PREDICTED, 16'sd0,     1'b0},
			'{ROW_CFG,    REG_FF_COEF_1, COEF_MIN,    PREDICTED, 16'sd0,     1'b0},
			'{ROW_CFG,    REG_FF_COEF_2, COEF_MAX,    PREDICTED, 16'sd0,     1'b0},
			'{ROW_CFG,    REG_FF_COEF_3, 16'sd8192,   PREDICTED, 16'sd0,     1'b0},
			'{ROW_CFG,    REG_FB_COEF_1, COEF_MIN,    PREDICTED, 16'sd0,     1'b0},
			'{ROW_CFG,    REG_FB_COEF_2, COEF_MAX,    PREDICTED, 16'sd0,     1'b0},
			'{ROW_CFG,    REG_FB_COEF_3, -16'sd16384, PREDICTED, 16'sd0,     1'b0},
			'{ROW_CFG,    REG_FB_COEF_4, 16'sd4096,   PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            16'sd12345,  PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            SMP_MIN,     PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            SMP_MAX,     PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            -16'sd20000, PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            16'sd0,      PREDICTED, 16'sd0,     1'b0},
			'{ROW_SAMPLE, '0,            16'sd777,    PREDICTED, 16'sd0,     1'b0}
		};
		no_result = '0;

		// Predictor and bookkeeping start from the reset state.
		for (int r = 0; r < NUM_REGS; r++)
			coef_bank[r] = '0;
		coef_bank[REG_FF_COEF_0] = FF0_RESET;
		for (int k = 0; k < MAX_TAPS - 1; k++)
			x_hist[k] = '0;
		for (int k = 0; k < MAX_TAPS; k++)
			y_hist[k] = '0;
		typed_pending = 1'b0;
		typed_result  = '0;
		sent_count    = 0;
		recv_count    = 0;
		errors        = 0;
		burst_left    = 0;
		no_idle       = 1'b0;

		// Every input known from time zero while reset is held.
		arst_n              = 1'b0;
		smp_in_if.valid     = 1'b0;
		smp_in_if.sample_in = '0;
		cfg_if.valid        = 1'b0;
		cfg_if.index        = '0;
		cfg_if.data         = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: writes only once the filter has gone idle.
		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_table[i].kind == ROW_CFG) begin
				if (i == 0 || dir_table[i-1].kind != ROW_CFG)
					wait_idle();
				write_reg(dir_table[i].idx, dir_table[i].value);
				if (i == DIR_ROWS - 1 || dir_table[i+1].kind != ROW_CFG)
					cfg_if.valid <= 1'b0;
			end else begin
				send_sample(dir_table[i].value, dir_table[i].typed,
					    '{dir_table[i].exp_sample, dir_table[i].exp_clip});
			end
		end

		// Random phases, each with a fresh coefficient set.
		for (int p = 0; p < PHASES; p++) begin
			wait_idle();
			no_idle = (p % 4 == 3);
			ff_style = coef_style_t'($urandom_range(0, 3));
			fb_style = ($urandom_range(0, 3) == 0) ? coef_style_t'($urandom_range(0, 2))
								 : CS_SMALL;
			for (int r = 0; r < NUM_REGS; r++) begin
				if (p == 0)
					value = COEF_MAX;
				else if (p == 1)
					value = COEF_MIN;
				else if (p == 2)
					value = (r == REG_FF_COEF_0) ? FF0_RESET : '0;
				else if (r < REG_FB_COEF_1)
					value = pick_coef(ff_style);
				else
					value = pick_coef(fb_style);
				write_reg(r[CFG_IDX_BITS-1:0], value);
			end
			// Writes past the register file must leave the coefficients alone.
			if ($urandom_range(0, 1))
				write_reg(CFG_IDX_BITS'($urandom_range(NUM_REGS, CFG_IDX_TOP)),
					  16'($urandom));
			cfg_if.valid <= 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_sample(pick_sample(), PREDICTED, no_result);
		end

		// Drain, let the pipeline settle, then give the verdict.
		wait_idle();
		repeat (SETTLE) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors++;
			$display("%0t %0d results never arrived", $time, expected_results.size());
		end
		if (errors == 0)
			$display("iir_arma_filter_top verification clean");
		else
			$display("iir_arma_filter_top verification failed");
		$finish;
	end

endmodule
